>>> hw/rtl/skq_pkg.sv
// Shared types and constants for the sorted key list queue.
// Used by sorted_key_list_queue and its port checker, skq_checker.
// Depends on nothing.
package skq_pkg;

  // Default sizing of the list
  localparam int CAPACITY_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed field widths on the streaming ports
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int HANDLE_W   = 4;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W  = 72;   // 68 bits of fields, zero padded
  localparam int OUT_TDATA_W = 112;  // 106 bits of fields, zero padded

  // Operation selector carried on in_tuser
  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_POP        = 2'd1,
    OP_REMOVE_KEY = 2'd2,
    OP_REMOVE_HDL = 2'd3
  } opcode_t;

  // Outcome carried on out_tuser
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

endpackage

>>> hw/rtl/sorted_key_list_queue.sv
// Top level of the sorted key list queue: entry memory, slot free map and sequencer.
// Depends on skq_pkg.
//
// Sorted key list queue. Holds up to CAPACITY (key, payload) entries in ascending key
// order in a single-port-write, single-port-read entry memory; each entry owns a slot
// handle taken as the lowest free slot from a free map. One transaction on the input
// channel (in_tuser = opcode) inserts, pops the head, removes every entry with a key, or
// removes one entry by handle; exactly one result transaction follows, carrying status on
// out_tuser and slot, popped payload, head and count on out_tdata. The block takes one
// transaction at a time and drops in_tready until its result is in the output register.
// Every entry move goes through the one memory read port and one key/handle compare, with
// one read state and one compare state per entry visited. A finished result sits in an
// output register, so the next transaction is accepted while it waits. No clearing pass is
// needed after reset.
module sorted_key_list_queue #(
  parameter int CAPACITY     = skq_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = skq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: key [31:0], data_in [63:32], entry_handle [67:64]
  input  logic [skq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode [1:0]
  input  logic [1:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: entry_slot [3:0], popped_data [35:4], head_valid [36],
  //            head_key [68:37], head_data [100:69], entry_count [105:101]
  output logic [skq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  localparam int PW     = (PAYLOAD_BITS < skq_pkg::DATA_W) ? PAYLOAD_BITS : skq_pkg::DATA_W;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int HCMP_W = SLOT_W + skq_pkg::HANDLE_W;
  localparam int CEXT_W = CNT_W + skq_pkg::COUNT_W;

  typedef struct packed {
    logic [skq_pkg::KEY_W-1:0] key;
    logic [PW-1:0]             data;
    logic [SLOT_W-1:0]         slot;
  } entry_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FREE    = 8'b0000_0010,
    S_INS_RD  = 8'b0000_0100,
    S_INS_CMP = 8'b0000_1000,
    S_CMP_RD  = 8'b0001_0000,
    S_CMP_CHK = 8'b0010_0000,
    S_HEAD_RD = 8'b0100_0000,
    S_HEAD_LD = 8'b1000_0000
  } state_t;

  // Control state
  state_t                state_r, state_nxt;
  skq_pkg::opcode_t      op_r, op_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CAPACITY-1:0]   free_map_r, free_map_nxt;
  logic [CNT_W-1:0]      rp_r, rp_nxt;       // scan index, read pointer or insert position
  logic [CNT_W-1:0]      wp_r, wp_nxt;       // compaction write pointer
  logic                  found_r, found_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;

  // Operands and working results
  logic [skq_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [PW-1:0]                  data_r, data_nxt;
  logic [skq_pkg::HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [SLOT_W-1:0]              slot_r, slot_nxt;
  skq_pkg::status_t               status_r, status_nxt;
  logic [PW-1:0]                  popped_r, popped_nxt;

  // Output register
  skq_pkg::status_t               o_status_r, o_status_nxt;
  logic [skq_pkg::HANDLE_W-1:0]   o_slot_r, o_slot_nxt;
  logic [skq_pkg::DATA_W-1:0]     o_popped_r, o_popped_nxt;
  logic                           o_hvalid_r, o_hvalid_nxt;
  logic [skq_pkg::KEY_W-1:0]      o_hkey_r, o_hkey_nxt;
  logic [skq_pkg::DATA_W-1:0]     o_hdata_r, o_hdata_nxt;
  logic [skq_pkg::COUNT_W-1:0]    o_count_r, o_count_nxt;

  // Entry memory
  entry_t            mem [CAPACITY];
  entry_t            rdata_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  logic              in_acc;
  logic [CNT_W-1:0]  rp_dec;
  logic [HCMP_W-1:0] slot_ext;
  logic [CEXT_W-1:0] count_ext;
  logic              match;
  entry_t            new_entry;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign rp_dec    = rp_r - CNT_W'(1);
  assign slot_ext  = HCMP_W'(slot_r);
  assign count_ext = CEXT_W'(count_r);
  assign new_entry = '{key: key_r, data: data_r, slot: slot_r};

  // Drop decision for the compaction pass
  always_comb begin
    match = 1'b0;
    unique case (op_r)
      skq_pkg::OP_POP:        match = (rp_r == '0);
      skq_pkg::OP_REMOVE_KEY: match = (rdata_r.key == key_r);
      skq_pkg::OP_REMOVE_HDL: match = !found_r &&
                                      (HCMP_W'(rdata_r.slot) == HCMP_W'(handle_r));
      default:                match = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    free_map_nxt   = free_map_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    found_nxt      = found_r;
    key_nxt        = key_r;
    data_nxt       = data_r;
    handle_nxt     = handle_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    popped_nxt     = popped_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    o_status_nxt   = o_status_r;
    o_slot_nxt     = o_slot_r;
    o_popped_nxt   = o_popped_r;
    o_hvalid_nxt   = o_hvalid_r;
    o_hkey_nxt     = o_hkey_r;
    o_hdata_nxt    = o_hdata_r;
    o_count_nxt    = o_count_r;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_waddr      = rp_r[SLOT_W-1:0];
    mem_wdata      = new_entry;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = skq_pkg::opcode_t'(in_tuser);
          key_nxt    = in_tdata[31:0];
          data_nxt   = in_tdata[32 +: PW];
          handle_nxt = in_tdata[67:64];
          slot_nxt   = '0;
          status_nxt = skq_pkg::ST_DONE;
          popped_nxt = '0;
          found_nxt  = 1'b0;
          rp_nxt     = '0;
          wp_nxt     = '0;
          if (skq_pkg::opcode_t'(in_tuser) == skq_pkg::OP_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = skq_pkg::ST_FULL;
              state_nxt  = S_HEAD_RD;
            end else begin
              state_nxt = S_FREE;
            end
          end else begin
            state_nxt = S_CMP_RD;
          end
        end
      end

      // Walk the free map for the lowest free slot
      S_FREE: begin
        if (free_map_r[rp_r[SLOT_W-1:0]]) begin
          slot_nxt  = rp_r[SLOT_W-1:0];
          rp_nxt    = count_r;
          state_nxt = S_INS_RD;
        end else begin
          rp_nxt = rp_r + CNT_W'(1);
        end
      end

      // Insert: shift entries with key >= new key up by one, from the tail down
      S_INS_RD: begin
        if (rp_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_HEAD_RD;
          free_map_nxt[slot_r] = 1'b0;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          rd_addr   = rp_dec[SLOT_W-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_r.key >= key_r) begin
          mem_wdata = rdata_r;
          rp_nxt    = rp_dec;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_HEAD_RD;
          free_map_nxt[slot_r] = 1'b0;
          count_nxt = count_r + CNT_W'(1);
        end
      end

      // Removal: one compaction pass over the held entries
      S_CMP_RD: begin
        if (rp_r == count_r) begin
          count_nxt  = wp_r;
          status_nxt = found_r ? skq_pkg::ST_DONE : skq_pkg::ST_MISS;
          state_nxt  = S_HEAD_RD;
        end else begin
          rd_addr   = rp_r[SLOT_W-1:0];
          state_nxt = S_CMP_CHK;
        end
      end

      S_CMP_CHK: begin
        if (match) begin
          found_nxt = 1'b1;
          free_map_nxt[rdata_r.slot] = 1'b1;
          if (op_r == skq_pkg::OP_POP) begin
            popped_nxt = rdata_r.data;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wp_r[SLOT_W-1:0];
          mem_wdata = rdata_r;
          wp_nxt    = wp_r + CNT_W'(1);
        end
        rp_nxt    = rp_r + CNT_W'(1);
        state_nxt = S_CMP_RD;
      end

      // Fetch the head entry (address 0 is the default read address)
      S_HEAD_RD: begin
        state_nxt = S_HEAD_LD;
      end

      // Load the result once the output register is free
      S_HEAD_LD: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          o_status_nxt   = status_r;
          o_slot_nxt     = (status_r == skq_pkg::ST_DONE && op_r == skq_pkg::OP_INSERT) ?
                           slot_ext[skq_pkg::HANDLE_W-1:0] : '0;
          o_popped_nxt   = skq_pkg::DATA_W'(popped_r);
          o_hvalid_nxt   = (count_r != '0);
          o_hkey_nxt     = (count_r != '0) ? rdata_r.key : '0;
          o_hdata_nxt    = (count_r != '0) ? skq_pkg::DATA_W'(rdata_r.data) : '0;
          o_count_nxt    = count_ext[skq_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      free_map_r   <= '1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      free_map_r   <= free_map_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Operand, working and output registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    rp_r       <= rp_nxt;
    wp_r       <= wp_nxt;
    found_r    <= found_nxt;
    key_r      <= key_nxt;
    data_r     <= data_nxt;
    handle_r   <= handle_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    popped_r   <= popped_nxt;
    o_status_r <= o_status_nxt;
    o_slot_r   <= o_slot_nxt;
    o_popped_r <= o_popped_nxt;
    o_hvalid_r <= o_hvalid_nxt;
    o_hkey_r   <= o_hkey_nxt;
    o_hdata_r  <= o_hdata_nxt;
    o_count_r  <= o_count_nxt;
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  // Result channel
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {6'd0, o_count_r, o_hdata_r, o_hkey_r, o_hvalid_r, o_popped_r, o_slot_r};

endmodule

>>> hw/rtl/skq_checker.sv
// Port-level assertions for the sorted key list queue, bound to its top level.
// Depends on skq_pkg and sorted_key_list_queue.
module skq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [skq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // A stalled result transaction holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The block works on one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an operation is in progress");

  // A full insert leaves a nonempty list and gives no slot
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == skq_pkg::ST_FULL |-> out_tdata[36] && out_tdata[3:0] == 4'd0)
    else $error("full status with empty head or a slot handle");

  // An empty head reads as zero
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[36] |-> out_tdata[68:37] == '0 && out_tdata[100:69] == '0)
    else $error("empty list shows a nonzero head");

endmodule

bind sorted_key_list_queue skq_checker u_skq_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for sorted_key_list_queue: directed table, then random traffic.
// Holds its own model of the sorted list and slot pool and checks every result transaction.
// Depends on skq_pkg and the sorted_key_list_queue RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 16;
  localparam int RAND_ITEMS = 1200;
  localparam int IDLE_PCT   = 31;
  localparam int TAIL_WAIT  = 60;

  // One result transaction, unpacked into its fields
  typedef struct packed {
    skq_pkg::status_t status;
    logic [3:0]       slot;
    logic [31:0]      popped;
    logic             head_valid;
    logic [31:0]      head_key;
    logic [31:0]      head_data;
    logic [4:0]       count;
  } queue_result_t;

  // Directed row: operation, repeat count, and an optional typed-in result
  typedef struct packed {
    skq_pkg::opcode_t op;
    logic [31:0]      key;
    logic [31:0]      data;
    logic [3:0]       hdl;
    logic [4:0]       reps;
    logic             typed;
    queue_result_t    res;
  } dir_row_t;

  localparam queue_result_t NO_RES = '0;
  localparam int N_DIR = 22;

  // Directed stimulus; typed results only where obvious
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // empty list: every removal misses
    '{skq_pkg::OP_POP, 32'd0, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_MISS, 4'd0, 32'd0, 1'b0, 32'd0, 32'd0, 5'd0}},
    '{skq_pkg::OP_REMOVE_KEY, 32'd5, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_MISS, 4'd0, 32'd0, 1'b0, 32'd0, 32'd0, 5'd0}},
    '{skq_pkg::OP_REMOVE_HDL, 32'd0, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_MISS, 4'd0, 32'd0, 1'b0, 32'd0, 32'd0, 5'd0}},
    // field extremes
    '{skq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_DONE, 4'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1}},
    '{skq_pkg::OP_INSERT, 32'd0, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_DONE, 4'd1, 32'd0, 1'b1, 32'd0, 32'd0, 5'd2}},
    // equal keys: the newer one goes first
    '{skq_pkg::OP_INSERT, 32'd100, 32'h0000_00A1, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_INSERT, 32'd100, 32'h0000_00B2, 4'd0, 5'd1, 1'b0, NO_RES},
    // free slot handle and absent key
    '{skq_pkg::OP_REMOVE_HDL, 32'd0, 32'd0, 4'd15, 5'd1, 1'b1,
      '{skq_pkg::ST_MISS, 4'd0, 32'd0, 1'b1, 32'd0, 32'd0, 5'd4}},
    '{skq_pkg::OP_REMOVE_KEY, 32'd50, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_MISS, 4'd0, 32'd0, 1'b1, 32'd0, 32'd0, 5'd4}},
    '{skq_pkg::OP_REMOVE_KEY, 32'd100, 32'd0, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_POP, 32'd0, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_DONE, 4'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1}},
    '{skq_pkg::OP_REMOVE_HDL, 32'd0, 32'd0, 4'd0, 5'd1, 1'b1,
      '{skq_pkg::ST_DONE, 4'd0, 32'd0, 1'b0, 32'd0, 32'd0, 5'd0}},
    // fill to capacity with descending keys, then overflow
    '{skq_pkg::OP_INSERT, 32'd1000, 32'h5A5A_0000, 4'd0, 5'd16, 1'b0, NO_RES},
    '{skq_pkg::OP_INSERT, 32'd7, 32'hFFFF_FFFF, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_REMOVE_HDL, 32'd0, 32'd0, 4'd15, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_INSERT, 32'd1000, 32'd0, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_REMOVE_KEY, 32'hFFFF_FFFF, 32'd0, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_POP, 32'd0, 32'd0, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_REMOVE_HDL, 32'd0, 32'd0, 4'd10, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_REMOVE_HDL, 32'd0, 32'd0, 4'd5, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 4'd0, 5'd1, 1'b0, NO_RES},
    '{skq_pkg::OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 4'd0, 5'd1, 1'b0, NO_RES}
  };

  logic                            clk;
  logic                            rst_n;
  logic [skq_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [skq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            out_tvalid;
  logic                            out_tready;

  // Model of the list: sorted entries and the slot pool
  logic [31:0]      list_keys  [SLOTS];
  logic [31:0]      list_data  [SLOTS];
  logic [3:0]       list_slots [SLOTS];
  int               list_count;
  logic [SLOTS-1:0] slot_free;

  queue_result_t pending_results [$];
  int            mismatch_count;
  bit            calm;

  sorted_key_list_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  // Delete the list entry at pos and return its slot to the pool
  function automatic void drop_entry(int pos);
    slot_free[list_slots[pos]] = 1'b1;
    for (int i = pos; i + 1 < list_count; i++) begin
      list_keys[i]  = list_keys[i+1];
      list_data[i]  = list_data[i+1];
      list_slots[i] = list_slots[i+1];
    end
    list_count--;
  endfunction

  // Apply one operation to the model and return the result it should produce
  function automatic queue_result_t apply_queue_op(skq_pkg::opcode_t op,
                                                   logic [31:0] key,
                                                   logic [31:0] data, logic [3:0] hdl);
    queue_result_t r;
    int            slot;
    int            pos;
    bit            hit;
    r    = '0;
    slot = SLOTS;
    pos  = 0;
    hit  = 1'b0;
    case (op)
      skq_pkg::OP_INSERT: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (slot_free[i]) slot = i;
        if (slot >= SLOTS || list_count >= SLOTS) begin
          r.status = skq_pkg::ST_FULL;
        end else begin
          while (pos < list_count && list_keys[pos] < key) pos++;
          for (int i = list_count; i > pos; i--) begin
            list_keys[i]  = list_keys[i-1];
            list_data[i]  = list_data[i-1];
            list_slots[i] = list_slots[i-1];
          end
          list_keys[pos]  = key;
          list_data[pos]  = data;
          list_slots[pos] = slot[3:0];
          slot_free[slot] = 1'b0;
          list_count++;
          r.slot = slot[3:0];
        end
      end
      skq_pkg::OP_POP: begin
        if (list_count == 0) begin
          r.status = skq_pkg::ST_MISS;
        end else begin
          r.popped = list_data[0];
          drop_entry(0);
        end
      end
      skq_pkg::OP_REMOVE_KEY: begin
        while (pos < list_count && list_keys[pos] <= key) begin
          if (list_keys[pos] == key) begin
            drop_entry(pos);
            hit = 1'b1;
          end else begin
            pos++;
          end
        end
        if (!hit) r.status = skq_pkg::ST_MISS;
      end
      default: begin
        for (int i = 0; i < list_count && !hit; i++)
          if (list_slots[i] == hdl) begin
            drop_entry(i);
            hit = 1'b1;
          end
        if (!hit) r.status = skq_pkg::ST_MISS;
      end
    endcase
    r.head_valid = (list_count > 0);
    r.head_key   = (list_count > 0) ? list_keys[0] : 32'd0;
    r.head_data  = (list_count > 0) ? list_data[0] : 32'd0;
    r.count      = list_count[4:0];
    return r;
  endfunction

  // Present one input transaction, wait for acceptance, record the expected result
  task automatic send_op(skq_pkg::opcode_t op, logic [31:0] key, logic [31:0] data,
                         logic [3:0] hdl, bit typed, queue_result_t typed_res);
    queue_result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'd0, hdl, data, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_queue_op(op, key, data, hdl);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // Mostly small keys so that equal keys and hits on removal are common
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return 32'($urandom_range(0, 15));
    if (sel == 6) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    return $urandom;
  endfunction

  // Random receiver stalls
  always @(negedge clk)
    out_tready = calm || ($urandom_range(0, 99) >= IDLE_PCT);

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",      32'(want.status),     32'(out_tuser));
        check_field("entry_slot",  32'(want.slot),       32'(out_tdata[3:0]));
        check_field("popped_data", want.popped,          out_tdata[35:4]);
        check_field("head_valid",  32'(want.head_valid), 32'(out_tdata[36]));
        check_field("head_key",    want.head_key,        out_tdata[68:37]);
        check_field("head_data",   want.head_data,       out_tdata[100:69]);
        check_field("entry_count", 32'(want.count),      32'(out_tdata[105:101]));
      end
    end
  end

  // Main sequence
  initial begin
    skq_pkg::opcode_t op;
    logic [31:0]      key;
    logic [3:0]       hdl;
    int               ins_pct;
    int               sel;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = skq_pkg::OP_INSERT;
    in_tdata       = '0;
    out_tready     = 1'b0;
    calm           = 1'b0;
    mismatch_count = 0;
    list_count     = 0;
    slot_free      = '1;
    for (int i = 0; i < SLOTS; i++) begin
      list_keys[i]  = '0;
      list_data[i]  = '0;
      list_slots[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (DIR_ROWS[r])
      for (int k = 0; k < DIR_ROWS[r].reps; k++)
        send_op(DIR_ROWS[r].op, DIR_ROWS[r].key - k, DIR_ROWS[r].data + k,
                DIR_ROWS[r].hdl, DIR_ROWS[r].typed, DIR_ROWS[r].res);

    // random traffic, alternating fill and drain phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm    = (n >= 500 && n < 700);
      ins_pct = ((n / 150) % 2 == 0) ? 65 : 25;
      sel     = $urandom_range(0, 99);
      key     = pick_key();
      hdl     = 4'($urandom_range(0, 15));
      if (sel < ins_pct) begin
        op = skq_pkg::OP_INSERT;
      end else if (sel < ins_pct + (100 - ins_pct) / 3) begin
        op = skq_pkg::OP_POP;
      end else if (sel < ins_pct + 2 * (100 - ins_pct) / 3) begin
        op = skq_pkg::OP_REMOVE_KEY;
        if (list_count > 0 && $urandom_range(0, 9) < 7)
          key = list_keys[$urandom_range(0, list_count - 1)];
      end else begin
        op = skq_pkg::OP_REMOVE_HDL;
        if (list_count > 0 && $urandom_range(0, 9) < 7)
          hdl = list_slots[$urandom_range(0, list_count - 1)];
      end
      send_op(op, key, $urandom, hdl, 1'b0, NO_RES);
    end
    in_tvalid = 1'b0;
    calm      = 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/skq_pkg.sv
hw/rtl/sorted_key_list_queue.sv
hw/rtl/skq_checker.sv
verif/tb_top.sv
